// ===== hw/rtl/kps_pkg.sv =====
// kps_pkg: shared types and constants of the keystroke playout sequencer
// no dependencies; used by the channel interfaces and all rtl modules
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

   localparam int KEY_W      = 8;
   localparam int SIZE_W     = 8;
   localparam int CFG_W      = 16;
   localparam int SINCE_W    = 17;
   localparam int PEND_OUT_W = 7;
   localparam int CSR_IDX_W  = 2;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd2;

   localparam logic [CFG_W-1:0] HOLD_RESET    = 16'd20;
   localparam logic [CFG_W-1:0] GAP_RESET     = 16'd20;
   localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd1000;

   localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } kps_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] hold_ticks;
      logic [CFG_W-1:0] gap_ticks;
      logic [CFG_W-1:0] mount_timeout_ticks;
   } kps_cfg_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } kps_mem_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/kps_channels.sv =====
// kps_req_if / kps_rsp_if: valid-ready channels for key items and result items
// depends on kps_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface kps_req_if;
   import kps_pkg::*;
   logic              valid;
   logic              ready;
   logic              command;
   logic [KEY_W-1:0]  keycode;
   logic              batch_first;
   logic              batch_last;
   logic [SIZE_W-1:0] batch_size;
   logic              host_mounted;
   logic              endpoint_ready;

   modport source(output valid, command, keycode, batch_first, batch_last, batch_size,
                  host_mounted, endpoint_ready, input ready);
   modport sink(input valid, command, keycode, batch_first, batch_last, batch_size,
                host_mounted, endpoint_ready, output ready);
endinterface

interface kps_rsp_if;
   import kps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  report_valid;
   logic [KEY_W-1:0]      report_keycode;
   logic                  batch_rejected;
   logic                  keys_flushed;
   logic [PEND_OUT_W-1:0] pending_keys;

   modport source(output valid, report_valid, report_keycode, batch_rejected, keys_flushed,
                  pending_keys, input ready);
   modport sink(input valid, report_valid, report_keycode, batch_rejected, keys_flushed,
                pending_keys, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kps_key_store.sv =====
// kps_key_store: keycode queue memory, one write and one registered read port
// depends on kps_pkg
`timescale 1ns / 1ps
`default_nettype none

module kps_key_store #(
   parameter int QUEUE_DEPTH = 64,
   parameter int SLOT_W      = 6
) (
   input  wire                          clock,
   input  kps_pkg::kps_mem_ctl_type     mem_ctl,
   input  wire [SLOT_W-1:0]             waddr,
   input  wire [kps_pkg::KEY_W-1:0]     wdata,
   input  wire [SLOT_W-1:0]             raddr,
   output logic [kps_pkg::KEY_W-1:0]    rdata
);
   import kps_pkg::*;

   logic [KEY_W-1:0] mem [QUEUE_DEPTH];
   logic [KEY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/kps_sequencer.sv =====
// kps_sequencer: item control, queue pointers, hold/gap timing and watchdog
// depends on kps_pkg, kps_channels; drives kps_key_store
`timescale 1ns / 1ps
`default_nettype none

module kps_sequencer #(
   parameter int QUEUE_DEPTH = 64,
   parameter int SLOT_W      = 6,
   parameter int CNT_W       = 7
) (
   input  wire                        clock,
   input  wire                        reset,
   kps_req_if.sink                    req_ch,
   kps_rsp_if.source                  rsp_ch,
   input  kps_pkg::kps_cfg_type       cfg,
   output kps_pkg::kps_mem_ctl_type   mem_ctl,
   output logic [SLOT_W-1:0]          mem_waddr,
   output logic [kps_pkg::KEY_W-1:0]  mem_wdata,
   output logic [SLOT_W-1:0]          mem_raddr,
   input  wire [kps_pkg::KEY_W-1:0]   mem_rdata
);
   import kps_pkg::*;

   localparam int CHK_W = CNT_W + SIZE_W + 1;
   localparam logic [CNT_W:0] DEPTH_SUM = (CNT_W+1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

   kps_state_type state_ff, state_in;

   // latched item
   logic              cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              first_ff;
   logic              last_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              mounted_ff;
   logic              ep_ready_ff;

   logic [SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [CNT_W-1:0]   pending_ff, pending_in;
   logic               release_ff, release_in;
   logic [CFG_W-1:0]   wait_ff, wait_in;
   logic [SINCE_W-1:0] since_ff, since_in;
   logic               taken_ff, taken_in;

   logic                  rsp_valid_ff;
   logic                  rpt_valid_ff, rpt_valid_in;
   logic [KEY_W-1:0]      rpt_key_ff, rpt_key_in;
   logic                  rejected_ff, rejected_in;
   logic                  flushed_ff, flushed_in;
   logic [PEND_OUT_W-1:0] pend_out_ff, pend_out_in;

   logic                  accept;
   logic                  advance;
   logic                  store_key;
   logic [CNT_W:0]        slot_sum;
   logic [SLOT_W-1:0]     wr_slot;
   logic [CNT_W+PEND_OUT_W-1:0] pend_wide;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ch.ready = 1'b0;
      advance      = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_EXEC: advance = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   // item execution
   always_comb begin
      read_slot_in = read_slot_ff;
      pending_in   = pending_ff;
      release_in   = release_ff;
      wait_in      = wait_ff;
      since_in     = since_ff;
      taken_in     = taken_ff;
      rpt_valid_in = 1'b0;
      rpt_key_in   = '0;
      rejected_in  = 1'b0;
      flushed_in   = 1'b0;
      store_key    = 1'b0;
      slot_sum     = '0;
      wr_slot      = '0;

      if (cmd_ff == CMD_ENQUEUE) begin
         if (first_ff) begin
            if ((CHK_W'(pending_ff) + CHK_W'(size_ff)) > CHK_W'(QUEUE_DEPTH)) begin
               taken_in    = 1'b0;
               rejected_in = 1'b1;
            end else begin
               taken_in = 1'b1;
               if (pending_ff == '0) begin
                  read_slot_in = '0;
                  release_in   = 1'b0;
                  wait_in      = '0;
                  since_in     = '0;
               end
            end
         end
         slot_sum = (CNT_W+1)'(read_slot_in) + (CNT_W+1)'(pending_ff);
         if (slot_sum >= DEPTH_SUM) begin
            slot_sum = slot_sum - DEPTH_SUM;
         end
         wr_slot = slot_sum[SLOT_W-1:0];
         if (taken_in && (pending_ff < DEPTH_CNT)) begin
            store_key  = 1'b1;
            pending_in = pending_ff + 1'b1;
         end
         if (last_ff) begin
            taken_in = 1'b0;
         end
      end else begin
         if (wait_ff != '0) begin
            wait_in = wait_ff - 1'b1;
         end
         if (since_ff != SINCE_MAX) begin
            since_in = since_ff + 1'b1;
         end
         if (pending_ff != '0) begin
            if (!mounted_ff || !ep_ready_ff) begin
               if (since_in > SINCE_W'(cfg.mount_timeout_ticks)) begin
                  pending_in   = '0;
                  read_slot_in = '0;
                  release_in   = 1'b0;
                  flushed_in   = 1'b1;
               end
            end else if (wait_in == '0) begin
               rpt_valid_in = 1'b1;
               if (!release_ff) begin
                  rpt_key_in = mem_rdata;
                  release_in = 1'b1;
                  wait_in    = cfg.hold_ticks;
               end else begin
                  release_in = 1'b0;
                  pending_in = pending_ff - 1'b1;
                  if ((pending_in == '0) || (read_slot_ff == LAST_SLOT)) begin
                     read_slot_in = '0;
                  end else begin
                     read_slot_in = read_slot_ff + 1'b1;
                  end
                  wait_in  = cfg.gap_ticks;
                  since_in = '0;
               end
            end
         end
      end

      pend_wide   = {{PEND_OUT_W{1'b0}}, pending_in};
      pend_out_in = pend_wide[PEND_OUT_W-1:0];
   end

   assign mem_ctl.wr_en = advance && store_key;
   assign mem_ctl.rd_en = accept;
   assign mem_waddr     = wr_slot;
   assign mem_wdata     = key_ff;
   assign mem_raddr     = read_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_slot_ff <= '0;
         pending_ff   <= '0;
         release_ff   <= 1'b0;
         wait_ff      <= '0;
         since_ff     <= '0;
         taken_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (advance) begin
            read_slot_ff <= read_slot_in;
            pending_ff   <= pending_in;
            release_ff   <= release_in;
            wait_ff      <= wait_in;
            since_ff     <= since_in;
            taken_ff     <= taken_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_ch.command;
         key_ff      <= req_ch.keycode;
         first_ff    <= req_ch.batch_first;
         last_ff     <= req_ch.batch_last;
         size_ff     <= req_ch.batch_size;
         mounted_ff  <= req_ch.host_mounted;
         ep_ready_ff <= req_ch.endpoint_ready;
      end
      if (advance) begin
         rpt_valid_ff <= rpt_valid_in;
         rpt_key_ff   <= rpt_key_in;
         rejected_ff  <= rejected_in;
         flushed_ff   <= flushed_in;
         pend_out_ff  <= pend_out_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.report_valid   = rpt_valid_ff;
   assign rsp_ch.report_keycode = rpt_key_ff;
   assign rsp_ch.batch_rejected = rejected_ff;
   assign rsp_ch.keys_flushed   = flushed_ff;
   assign rsp_ch.pending_keys   = pend_out_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/keystroke_playout_sequencer.sv =====
// keystroke_playout_sequencer: top level, timing registers and checks
// depends on kps_pkg, kps_channels, kps_key_store, kps_sequencer
//
//   channel   dir  handshake        contents
//   req_ch    in   valid / ready    enqueue key or millisecond tick
//   rsp_ch    out  valid / ready    report, reject, flush flags, pending count
//   csr_*     in   csr_we           hold, gap and watchdog limits
//
// each item is accepted in ST_IDLE with the queue head read, then executed
// and written back in ST_EXEC; the key memory's registered read port sets this split
// execute waits while the previous result is not yet taken on rsp_ch
// reset is synchronous; the key memory is not cleared, only queued slots are read
`timescale 1ns / 1ps
`default_nettype none

module keystroke_playout_sequencer #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   kps_req_if.sink                          req_ch,
   kps_rsp_if.source                        rsp_ch,
   input  wire                              csr_we,
   input  wire [kps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [kps_pkg::CFG_W-1:0]         csr_wdata
);
   import kps_pkg::*;

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   kps_cfg_type     cfg_ff;
   kps_mem_ctl_type mem_ctl;
   logic [SLOT_W-1:0] mem_waddr;
   logic [SLOT_W-1:0] mem_raddr;
   logic [KEY_W-1:0]  mem_wdata;
   logic [KEY_W-1:0]  mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks          <= HOLD_RESET;
         cfg_ff.gap_ticks           <= GAP_RESET;
         cfg_ff.mount_timeout_ticks <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HOLD:    cfg_ff.hold_ticks          <= csr_wdata;
            CSR_GAP:     cfg_ff.gap_ticks           <= csr_wdata;
            CSR_TIMEOUT: cfg_ff.mount_timeout_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   kps_sequencer #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .SLOT_W     (SLOT_W),
      .CNT_W      (CNT_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .cfg      (cfg_ff),
      .mem_ctl  (mem_ctl),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata)
   );

   kps_key_store #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .SLOT_W     (SLOT_W)
   ) u_store (
      .clock  (clock),
      .mem_ctl(mem_ctl),
      .waddr  (mem_waddr),
      .wdata  (mem_wdata),
      .raddr  (mem_raddr),
      .rdata  (mem_rdata)
   );

   // one item in flight: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("item accepted while previous item executing");

   // reports only come from ticks, rejects and flushes never share a result with one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.report_valid) |-> (!rsp_ch.batch_rejected && !rsp_ch.keys_flushed))
      else $error("report combined with reject or flush");

   // a flush empties the queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.keys_flushed) |-> (rsp_ch.pending_keys == '0))
      else $error("keys left pending after flush");

endmodule

`default_nettype wire

// ===== dv/kps_playout_checker.sv =====
// kps_playout_checker: watches the item and result channels of the keystroke playout
// sequencer, tracks key queue, timers and watchdog, and compares every result item
// depends on kps_pkg and kps_channels
`timescale 1ns / 1ps

module kps_playout_checker (
   input  wire                          clock,
   input  wire                          reset,
   kps_req_if                           req,
   kps_rsp_if                           rsp,
   input  wire                          csr_we,
   input  wire [kps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [kps_pkg::CFG_W-1:0]     csr_wdata,
   output int                           mismatches,
   output int                           awaiting,
   output int                           reports,
   output int                           rejects,
   output int                           flushes
);
   import kps_pkg::*;

   localparam int QUEUE_DEPTH = 64;

   typedef struct packed {
      logic                  report_valid;
      logic [KEY_W-1:0]      report_keycode;
      logic                  batch_rejected;
      logic                  keys_flushed;
      logic [PEND_OUT_W-1:0] pending_keys;
   } key_report_type;

   key_report_type     expected_reports[$];
   logic [KEY_W-1:0]   key_mem [QUEUE_DEPTH];
   int                 head;
   int                 queued;
   logic               releasing;
   logic               taking;
   logic [CFG_W-1:0]   wait_left;
   logic [SINCE_W-1:0] since_progress;
   kps_cfg_type        timing;

   function automatic key_report_type play_step(logic command, logic [KEY_W-1:0] keycode,
                                                logic first, logic last,
                                                logic [SIZE_W-1:0] size,
                                                logic mounted, logic ready);
      key_report_type r;
      r = '0;
      if (command == CMD_ENQUEUE) begin
         if (first) begin
            if (queued + int'(size) > QUEUE_DEPTH) begin
               taking = 1'b0;
               r.batch_rejected = 1'b1;
            end else begin
               taking = 1'b1;
               // enqueue into an empty queue restarts the timing
               if (queued == 0) begin
                  head           = 0;
                  releasing      = 1'b0;
                  wait_left      = '0;
                  since_progress = '0;
               end
            end
         end
         if (taking && queued < QUEUE_DEPTH) begin
            key_mem[(head + queued) % QUEUE_DEPTH] = keycode;
            queued++;
         end
         if (last) taking = 1'b0;
      end else begin
         if (wait_left != '0) wait_left = wait_left - 1'b1;
         if (since_progress != SINCE_MAX) since_progress = since_progress + 1'b1;
         if (queued != 0) begin
            if (!mounted || !ready) begin
               if (since_progress > SINCE_W'(timing.mount_timeout_ticks)) begin
                  queued          = 0;
                  head            = 0;
                  releasing       = 1'b0;
                  r.keys_flushed  = 1'b1;
               end
            end else if (wait_left == '0) begin
               r.report_valid = 1'b1;
               if (!releasing) begin
                  r.report_keycode = key_mem[head];
                  releasing        = 1'b1;
                  wait_left        = timing.hold_ticks;
               end else begin
                  releasing = 1'b0;
                  queued--;
                  head = (queued == 0) ? 0 : (head + 1) % QUEUE_DEPTH;
                  wait_left      = timing.gap_ticks;
                  since_progress = '0;
               end
            end
         end
      end
      r.pending_keys = PEND_OUT_W'(queued);
      return r;
   endfunction

   task automatic compare_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      key_report_type want;
      if (reset) begin
         expected_reports.delete();
         head                       = 0;
         queued                     = 0;
         releasing                  = 1'b0;
         taking                     = 1'b0;
         wait_left                  = '0;
         since_progress             = '0;
         timing.hold_ticks          = HOLD_RESET;
         timing.gap_ticks           = GAP_RESET;
         timing.mount_timeout_ticks = TIMEOUT_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HOLD:    timing.hold_ticks          = csr_wdata;
               CSR_GAP:     timing.gap_ticks           = csr_wdata;
               CSR_TIMEOUT: timing.mount_timeout_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            expected_reports = {expected_reports,
                                play_step(req.command, req.keycode, req.batch_first,
                                          req.batch_last, req.batch_size,
                                          req.host_mounted, req.endpoint_ready)};
         if (rsp.valid && rsp.ready) begin
            if (expected_reports.size() == 0) begin
               $error("result item arrived with no prediction waiting");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("report_valid", want.report_valid, rsp.report_valid);
               compare_field("report_keycode", want.report_keycode, rsp.report_keycode);
               compare_field("batch_rejected", want.batch_rejected, rsp.batch_rejected);
               compare_field("keys_flushed", want.keys_flushed, rsp.keys_flushed);
               compare_field("pending_keys", want.pending_keys, rsp.pending_keys);
               if (want.report_valid) reports++;
               if (want.batch_rejected) rejects++;
               if (want.keys_flushed) flushes++;
            end
         end
      end
      awaiting = expected_reports.size();
   end

endmodule

// ===== dv/testbench.sv =====
// testbench: top of the keystroke playout sequencer bench; drives key and tick items,
// timing register writes and handshake stalls, and gives the verdict
// depends on kps_pkg, kps_channels, keystroke_playout_sequencer and kps_playout_checker
`timescale 1ns / 1ps

module testbench;
   import kps_pkg::*;

   localparam int QUIET_LIMIT     = 2000;
   localparam int ITEMS_PER_PHASE = 100;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   int send_idle_pct;
   int recv_stall_pct;
   int items_sent;
   int tick_span;
   int down_span;
   int mismatches;
   int awaiting;
   int reports;
   int rejects;
   int flushes;

   kps_req_if req_ch ();
   kps_rsp_if rsp_ch ();

   keystroke_playout_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kps_playout_checker playout_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .awaiting   (awaiting),
      .reports    (reports),
      .rejects    (rejects),
      .flushes    (flushes)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic offer_item(logic command, logic [KEY_W-1:0] keycode, logic first,
                             logic last, logic [SIZE_W-1:0] size, logic mounted,
                             logic ready);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.command        <= command;
      req_ch.keycode        <= keycode;
      req_ch.batch_first    <= first;
      req_ch.batch_last     <= last;
      req_ch.batch_size     <= size;
      req_ch.host_mounted   <= mounted;
      req_ch.endpoint_ready <= ready;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timing(int hold, int gap, int timeout);
      csr_we    <= 1'b1;
      csr_index <= CSR_HOLD;
      csr_wdata <= CFG_W'(hold);
      @(negedge clock);
      csr_index <= CSR_GAP;
      csr_wdata <= CFG_W'(gap);
      @(negedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= CFG_W'(timeout);
      @(negedge clock);
      csr_we    <= 1'b0;
      tick_span = (hold + gap + 2 > 40) ? 40 : hold + gap + 2;
      down_span = (timeout + 4 > 40) ? 40 : timeout + 4;
   endtask

   task automatic enqueue_batch(int n, int announced, bit closed);
      for (int i = 0; i < n; i++)
         offer_item(CMD_ENQUEUE, KEY_W'($urandom), i == 0, closed && i == n - 1,
                    SIZE_W'(announced), 1'($urandom), 1'($urandom));
   endtask

   task automatic run_ticks(int n, int up_pct);
      int pick;
      repeat (n) begin
         if ($urandom_range(99) < up_pct) begin
            offer_item(CMD_TICK, KEY_W'($urandom), 1'($urandom), 1'($urandom),
                       SIZE_W'($urandom), 1'b1, 1'b1);
         end else begin
            pick = $urandom_range(2);
            offer_item(CMD_TICK, KEY_W'($urandom), 1'($urandom), 1'($urandom),
                       SIZE_W'($urandom), pick == 1, pick == 0);
         end
      end
   endtask

   task automatic random_sequence();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 28) begin
         n = ($urandom_range(15) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         enqueue_batch(n, n, 1'b1);
      end else if (pick < 34) begin
         // size field at odds with the keys sent, or a batch left open
         n = ($urandom_range(7) == 0) ? 64 : $urandom_range(12, 1);
         enqueue_batch(n, ($urandom_range(3) == 0) ? 0 : $urandom_range(255, 1),
                       $urandom_range(3) != 0);
      end else if (pick < 38) begin
         offer_item(CMD_ENQUEUE, KEY_W'($urandom), 1'b0, 1'($urandom), SIZE_W'($urandom),
                    1'($urandom), 1'($urandom));
      end else if (pick < 85) begin
         run_ticks($urandom_range(tick_span, 1), 95);
      end else begin
         run_ticks($urandom_range(down_span, 1), 0);
      end
   endtask

   task automatic run_phase(int hold, int gap, int timeout, int idle_pct, int stall_pct);
      int stop_at;
      settle();
      write_timing(hold, gap, timeout);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at = items_sent + ITEMS_PER_PHASE;
      while (items_sent < stop_at) random_sequence();
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.command        = CMD_TICK;
      req_ch.keycode        = '0;
      req_ch.batch_first    = 1'b0;
      req_ch.batch_last     = 1'b0;
      req_ch.batch_size     = '0;
      req_ch.host_mounted   = 1'b0;
      req_ch.endpoint_ready = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_we                = 1'b0;
      csr_index             = CSR_HOLD;
      csr_wdata             = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_timing(2, 1, 3);
      // stray key, tick on an empty queue, then a batch of three
      offer_item(CMD_ENQUEUE, 8'hAA, 1'b0, 1'b1, 8'd1, 1'b1, 1'b1);
      offer_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1);
      offer_item(CMD_ENQUEUE, 8'h00, 1'b1, 1'b0, 8'd3, 1'b1, 1'b1);
      offer_item(CMD_ENQUEUE, 8'hFF, 1'b0, 1'b0, 8'd3, 1'b0, 1'b0);
      offer_item(CMD_ENQUEUE, 8'h81, 1'b0, 1'b1, 8'd3, 1'b1, 1'b1);
      // oversized batch dropped whole, then a zero size batch
      offer_item(CMD_ENQUEUE, 8'h11, 1'b1, 1'b0, 8'd255, 1'b1, 1'b1);
      offer_item(CMD_ENQUEUE, 8'h22, 1'b0, 1'b1, 8'd255, 1'b1, 1'b1);
      offer_item(CMD_ENQUEUE, 8'h7E, 1'b1, 1'b1, 8'd0, 1'b1, 1'b1);
      repeat (7) offer_item(CMD_TICK, 8'h5A, 1'b1, 1'b1, 8'hA5, 1'b1, 1'b1);
      // host away until the watchdog flushes during a held key
      offer_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1);
      offer_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0);
      repeat (3) offer_item(CMD_TICK, 8'hFF, 1'b0, 1'b0, 8'hFF, 1'b0, 1'b0);
      offer_item(CMD_ENQUEUE, 8'h01, 1'b1, 1'b0, 8'd2, 1'b0, 1'b0);
      offer_item(CMD_ENQUEUE, 8'h80, 1'b0, 1'b1, 8'd2, 1'b0, 1'b0);
      repeat (2) offer_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1);

      run_phase(3, 2, 8, 0, 0);
      run_phase(0, 0, 0, 46, 0);
      run_phase(65535, 65535, 65535, 0, 46);
      run_phase(1, 5, 2, 30, 30);
      run_phase(4, 0, 20, 0, 0);
      settle();

      $display("%0d items sent over six timing settings from zero to full scale", items_sent);
      $display("%0d reports, %0d rejected batches, %0d watchdog flushes, %0d mismatches",
               reports, rejects, flushes, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
